@@ src/sckd_pkg.sv @@
// ============================================================================
// sckd_pkg : scan code keyboard decoder package
// Shared constants, key codes, character maps, the result flag type and the queue pointer increment function.
// ============================================================================
package sckd_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_ONE  = 2'd1;
    localparam logic [1:0] PFX_TWO  = 2'd2;
    localparam logic [1:0] PFX_SAT  = 2'd3;

    localparam logic [7:0] SC_PREFIX = 8'hE0;

    localparam logic [6:0] KEY_DEL    = 7'h53;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_F1     = 7'h3B;
    localparam logic [6:0] KEY_F5     = 7'h3F;
    localparam logic [6:0] KEY_UP     = 7'h48;
    localparam logic [6:0] KEY_DOWN   = 7'h50;
    localparam logic [6:0] KEY_LEFT   = 7'h4B;
    localparam logic [6:0] KEY_RIGHT  = 7'h4D;

    localparam logic [3:0] ARW_UP    = 4'hB;
    localparam logic [3:0] ARW_DOWN  = 4'hC;
    localparam logic [3:0] ARW_LEFT  = 4'hD;
    localparam logic [3:0] ARW_RIGHT = 4'hE;

    localparam logic [6:0] CH_NUL     = 7'h00;
    localparam logic [6:0] CH_EOT     = 7'h04;
    localparam logic [6:0] CH_NEWLINE = 7'h0A;
    localparam logic [6:0] CH_UP_A    = 7'h41;
    localparam logic [6:0] CH_UP_D    = 7'h44;
    localparam logic [6:0] CH_UP_Z    = 7'h5A;
    localparam logic [6:0] CH_LO_A    = 7'h61;
    localparam logic [6:0] CH_LO_C    = 7'h63;
    localparam logic [6:0] CH_LO_D    = 7'h64;
    localparam logic [6:0] CH_LO_Z    = 7'h7A;
    localparam logic [6:0] CH_CASE    = 7'h20;

    localparam logic [6:0] PLAIN_MAP [0:63] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] SHIFT_MAP [0:63] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h00, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef struct packed {
        logic reboot_request;
        logic interrupt_signal;
        logic overflow;
        logic read_valid;
    } t_result;

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
        logic [FIFO_AW-1:0] r;
        if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + FIFO_AW'(1);
        end
        return r;
    endfunction

endpackage

@@ src/scan_code_keyboard_decoder.sv @@
// ============================================================================
// scan_code_keyboard_decoder : set-1 scan code decoder with character queue
// Input channel takes a scan byte (func 0) or a read request (func 1); every
// transfer in gives exactly one result transfer out, in order. Scan bytes
// update shift, control, alt and caps-lock, decode E0 sequences and push
// characters into a queue held in a synchronous memory; read requests pop
// one character. Result carries reboot, interrupt, overflow and read flags.
// The result passes through the memory read stage and the result register.
// Throughput: one transfer per cycle while o_stall is low. An E0 E0 key
// byte that stores both its code and the newline occupies the single memory
// write port twice, so the input stalls in the cycle after it.
// Reset (synchronous, active low): modifier state, prefix count, arrow code,
// pointers and fill count clear; queue contents stay undefined but are never
// read before being written. No clearing pass is needed.
// When the receiver stalls, the result register holds, a second result waits
// in the memory read stage, and then o_stall rises towards the sender.
// ============================================================================
module scan_code_keyboard_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [7:0] i_scan_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_reboot_request,
    output logic       o_interrupt_signal,
    output logic       o_overflow,
    output logic       o_read_valid,
    output logic [6:0] o_read_char
);
    import sckd_pkg::*;

    logic [6:0]         r_mem [0:FIFO_DEPTH-1];
    logic [6:0]         r_mem_q;

    logic               r_shift, r_ctrl, r_alt, r_caps;
    logic [1:0]         r_pc;
    logic [3:0]         r_arrow;
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_fill;
    logic               r_pend;
    logic [FIFO_AW-1:0] r_pend_addr;

    logic               r_s2_valid;
    t_result            r_s2;
    logic               r_out_valid;
    t_result            r_out;
    logic [6:0]         r_out_char;

    logic               n_shift, n_ctrl, n_alt, n_caps;
    logic [1:0]         n_pc;
    logic [3:0]         n_arrow;
    logic [FIFO_AW-1:0] n_wp, n_rp;
    logic [FIFO_CW-1:0] n_fill;
    t_result            res;
    logic               ovf;

    logic               acc_in, ld_out;
    logic               push1, push2, ok1, ok2;
    logic [6:0]         push_data;
    logic               wr_en, rd_en, pend_set;
    logic [FIFO_AW-1:0] wp1;
    logic [6:0]         code_k;
    logic               is_pfx;
    logic [1:0]         pc_eff;
    logic [6:0]         ch;

    assign ld_out  = !r_out_valid || !i_stall;
    assign o_stall = r_pend || (r_s2_valid && !ld_out);
    assign acc_in  = i_valid && !o_stall;

    assign o_valid            = r_out_valid;
    assign o_reboot_request   = r_out.reboot_request;
    assign o_interrupt_signal = r_out.interrupt_signal;
    assign o_overflow         = r_out.overflow;
    assign o_read_valid       = r_out.read_valid;
    assign o_read_char        = r_out_char;

    assign code_k = i_scan_code[6:0];
    assign is_pfx = (i_scan_code == SC_PREFIX);
    assign pc_eff = (is_pfx && r_pc != PFX_SAT) ? r_pc + 2'd1 : r_pc;

    always_comb begin
        ch = i_scan_code[6] ? CH_NUL
           : (r_shift ? SHIFT_MAP[i_scan_code[5:0]] : PLAIN_MAP[i_scan_code[5:0]]);
        if (r_caps && ((ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z))) begin
            ch = ch ^ CH_CASE;
        end
    end

    always_comb begin
        n_shift   = r_shift;
        n_ctrl    = r_ctrl;
        n_alt     = r_alt;
        n_caps    = r_caps;
        n_pc      = r_pc;
        n_arrow   = r_arrow;
        n_rp      = r_rp;
        res       = '0;
        push1     = 1'b0;
        push2     = 1'b0;
        push_data = CH_NUL;
        rd_en     = 1'b0;
        if (i_func == FUNC_READ) begin
            if (r_fill != '0) begin
                rd_en          = acc_in;
                res.read_valid = 1'b1;
                n_rp           = ptr_inc(r_rp);
            end
        end else begin
            n_pc = pc_eff;
            case (pc_eff)
                PFX_ONE: begin
                end
                PFX_TWO: begin
                    if (!is_pfx) begin
                        if (code_k == KEY_DEL) begin
                            res.reboot_request = r_ctrl && r_alt;
                        end else if (code_k == KEY_ALT) begin
                            n_alt = 1'b0;
                        end else if (code_k == KEY_CTRL) begin
                            n_ctrl = 1'b0;
                        end else begin
                            if (code_k == KEY_UP)    n_arrow = ARW_UP;
                            if (code_k == KEY_DOWN)  n_arrow = ARW_DOWN;
                            if (code_k == KEY_LEFT)  n_arrow = ARW_LEFT;
                            if (code_k == KEY_RIGHT) n_arrow = ARW_RIGHT;
                            push1     = 1'b1;
                            push2     = 1'b1;
                            push_data = {3'b000, n_arrow};
                            n_pc      = PFX_NONE;
                        end
                    end
                end
                default: begin
                    if (i_scan_code[7]) begin
                        if (code_k == KEY_LSHIFT || code_k == KEY_RSHIFT) n_shift = 1'b0;
                        if (code_k == KEY_CTRL) n_ctrl = 1'b0;
                        if (code_k == KEY_ALT)  n_alt  = 1'b0;
                    end else if (code_k == KEY_LSHIFT || code_k == KEY_RSHIFT) begin
                        n_shift = 1'b1;
                    end else if (code_k == KEY_ALT) begin
                        n_alt = 1'b1;
                    end else if (code_k == KEY_CTRL) begin
                        n_ctrl = 1'b1;
                    end else if (code_k == KEY_CAPS) begin
                        n_caps = !r_caps;
                    end else if (r_ctrl && r_alt && code_k == KEY_DEL) begin
                        res.reboot_request = 1'b1;
                    end else if (code_k >= KEY_F1 && code_k <= KEY_F5) begin
                    end else begin
                        push1     = 1'b1;
                        push_data = ch;
                        if (r_ctrl && ch == CH_LO_C) begin
                            res.interrupt_signal = 1'b1;
                            push_data            = CH_NEWLINE;
                        end else if (r_ctrl && (ch == CH_LO_D || ch == CH_UP_D)) begin
                            push_data = CH_EOT;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        ok1      = push1 && (r_fill != FIFO_CW'(FIFO_DEPTH));
        ok2      = push2 && ok1 && (r_fill != FIFO_CW'(FIFO_DEPTH - 1));
        ovf      = (push1 && !ok1) || (push2 && !ok2);
        wp1      = ptr_inc(r_wp);
        wr_en    = acc_in && ok1;
        pend_set = acc_in && ok2;
        n_wp     = r_wp;
        n_fill   = r_fill;
        if (ok2) begin
            n_wp   = ptr_inc(wp1);
            n_fill = r_fill + FIFO_CW'(2);
        end else if (ok1) begin
            n_wp   = wp1;
            n_fill = r_fill + FIFO_CW'(1);
        end else if (res.read_valid) begin
            n_fill = r_fill - FIFO_CW'(1);
        end
    end

    // queue memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_mem[r_pend_addr] <= CH_NEWLINE;
        end else if (wr_en) begin
            r_mem[r_wp] <= push_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 1'b0;
            r_ctrl      <= 1'b0;
            r_alt       <= 1'b0;
            r_caps      <= 1'b0;
            r_pc        <= PFX_NONE;
            r_arrow     <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= pend_set;
            if (acc_in) begin
                r_shift <= n_shift;
                r_ctrl  <= n_ctrl;
                r_alt   <= n_alt;
                r_caps  <= n_caps;
                r_pc    <= n_pc;
                r_arrow <= n_arrow;
                r_wp    <= n_wp;
                r_rp    <= n_rp;
                r_fill  <= n_fill;
            end
            if (acc_in) begin
                r_s2_valid <= 1'b1;
            end else if (ld_out) begin
                r_s2_valid <= 1'b0;
            end
            if (ld_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_set) begin
            r_pend_addr <= wp1;
        end
        if (acc_in) begin
            r_s2 <= '{reboot_request:   res.reboot_request,
                      interrupt_signal: res.interrupt_signal,
                      overflow:         ovf,
                      read_valid:       res.read_valid};
        end
        if (ld_out) begin
            r_out      <= r_s2;
            r_out_char <= r_s2.read_valid ? r_mem_q : CH_NUL;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FIFO_CW'(FIFO_DEPTH))
        else $error("fill count beyond queue depth");

    a_pend_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> !r_pend)
        else $error("deferred newline write longer than one cycle");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == FIFO_CW'(FIFO_DEPTH)) |-> (r_wp == r_rp))
        else $error("pointers disagree with fill count");

    a_pfx_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc == PFX_SAT |=> r_pc == PFX_SAT)
        else $error("saturated prefix count left saturation");

    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_valid) |->
            (!o_reboot_request && !o_interrupt_signal && !o_overflow))
        else $error("read result carries scan flags");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_read_valid) |-> (o_read_char == CH_NUL))
        else $error("character present without read");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench : scan code keyboard decoder
// Sends scan bytes and read requests over the valid/stall input channel and
// keeps its own model of the modifier keys, the E0 prefix count, the arrow
// code and the character queue. Every result transfer is compared field by
// field with the oldest expected result (the table's result for typed rows).
// A short directed table opens the run. Random key phrases follow, with read
// rates that fill the queue past full and then drain it.
// ============================================================================
module testbench;
    import sckd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic       reboot_request;
        logic       interrupt_signal;
        logic       overflow;
        logic       read_valid;
        logic [6:0] read_char;
    } kbd_result_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  code;
        logic        typed;
        kbd_result_t want;
    } stim_row_t;

    localparam kbd_result_t QUIET        = '0;
    localparam kbd_result_t READ_NUL     = '{1'b0, 1'b0, 1'b0, 1'b1, CH_NUL};
    localparam kbd_result_t RAISE_INTR   = '{1'b0, 1'b1, 1'b0, 1'b0, CH_NUL};
    localparam kbd_result_t RAISE_REBOOT = '{1'b1, 1'b0, 1'b0, 1'b0, CH_NUL};

    localparam logic [6:0] PLAIN_CHARS [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] SHIFTED_CHARS [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h00, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam stim_row_t DIRECTED [25] = '{
        '{FUNC_READ, 8'h00,                  1'b1, QUIET},
        '{FUNC_SCAN, 8'h00,                  1'b1, QUIET},
        '{FUNC_SCAN, 8'hFF,                  1'b1, QUIET},
        '{FUNC_SCAN, 8'h7F,                  1'b1, QUIET},
        '{FUNC_READ, 8'h00,                  1'b1, READ_NUL},
        '{FUNC_READ, 8'h00,                  1'b1, READ_NUL},
        '{FUNC_SCAN, {1'b0, KEY_CAPS},       1'b0, QUIET},
        '{FUNC_SCAN, 8'h10,                  1'b0, QUIET},
        '{FUNC_SCAN, {1'b0, KEY_LSHIFT},     1'b0, QUIET},
        '{FUNC_SCAN, 8'h10,                  1'b0, QUIET},
        '{FUNC_SCAN, {1'b1, KEY_LSHIFT},     1'b0, QUIET},
        '{FUNC_SCAN, {1'b0, KEY_F1},         1'b0, QUIET},
        '{FUNC_SCAN, {1'b0, KEY_F5},         1'b0, QUIET},
        '{FUNC_SCAN, {1'b0, KEY_CAPS},       1'b0, QUIET},
        '{FUNC_SCAN, {1'b0, KEY_CTRL},       1'b0, QUIET},
        '{FUNC_SCAN, 8'h2E,                  1'b1, RAISE_INTR},
        '{FUNC_SCAN, 8'h20,                  1'b0, QUIET},
        '{FUNC_SCAN, {1'b0, KEY_ALT},        1'b0, QUIET},
        '{FUNC_SCAN, {1'b0, KEY_DEL},        1'b1, RAISE_REBOOT},
        '{FUNC_SCAN, {1'b1, KEY_CTRL},       1'b0, QUIET},
        '{FUNC_SCAN, {1'b1, KEY_ALT},        1'b0, QUIET},
        '{FUNC_SCAN, SC_PREFIX,              1'b0, QUIET},
        '{FUNC_SCAN, SC_PREFIX,              1'b0, QUIET},
        '{FUNC_SCAN, {1'b1, KEY_UP},         1'b0, QUIET},
        '{FUNC_READ, 8'hFF,                  1'b0, QUIET}
    };

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_func      = FUNC_SCAN;
    logic [7:0] i_scan_code = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_reboot_request;
    logic       o_interrupt_signal;
    logic       o_overflow;
    logic       o_read_valid;
    logic [6:0] o_read_char;

    // model state
    logic       shift_held = 1'b0;
    logic       ctrl_held  = 1'b0;
    logic       alt_held   = 1'b0;
    logic       caps_lock  = 1'b0;
    logic [1:0] e0_count   = PFX_NONE;
    logic [3:0] arrow_code = 4'h0;
    logic [6:0] char_queue [$];

    kbd_result_t expected_results [$];
    int          errors       = 0;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    bit          calm         = 1'b0;

    scan_code_keyboard_decoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_func             (i_func),
        .i_scan_code        (i_scan_code),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_reboot_request   (o_reboot_request),
        .o_interrupt_signal (o_interrupt_signal),
        .o_overflow         (o_overflow),
        .o_read_valid       (o_read_valid),
        .o_read_char        (o_read_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic queue_char(input logic [6:0] ch);
        if (char_queue.size() >= FIFO_DEPTH) begin
            return 1'b1;
        end
        char_queue.push_back(ch);
        return 1'b0;
    endfunction

    function automatic kbd_result_t decode_item(input logic fn, input logic [7:0] code);
        kbd_result_t r;
        logic [6:0]  key;
        logic [6:0]  ch;
        r   = QUIET;
        key = code[6:0];
        if (fn == FUNC_READ) begin
            if (char_queue.size() != 0) begin
                r.read_valid = 1'b1;
                r.read_char  = char_queue.pop_front();
            end
        end else begin
            if (code == SC_PREFIX && e0_count != PFX_SAT) begin
                e0_count = e0_count + 2'd1;
            end
            if (e0_count == PFX_ONE) begin
                // swallow until the second prefix
            end else if (e0_count == PFX_TWO) begin
                if (code != SC_PREFIX) begin
                    if (key == KEY_DEL) begin
                        r.reboot_request = ctrl_held && alt_held;
                    end else if (key == KEY_ALT) begin
                        alt_held = 1'b0;
                    end else if (key == KEY_CTRL) begin
                        ctrl_held = 1'b0;
                    end else begin
                        case (key)
                            KEY_UP:    arrow_code = ARW_UP;
                            KEY_DOWN:  arrow_code = ARW_DOWN;
                            KEY_LEFT:  arrow_code = ARW_LEFT;
                            KEY_RIGHT: arrow_code = ARW_RIGHT;
                            default: ;
                        endcase
                        r.overflow = queue_char({3'b000, arrow_code});
                        r.overflow = queue_char(CH_NEWLINE) | r.overflow;
                        e0_count   = PFX_NONE;
                    end
                end
            end else if (code[7]) begin
                if (key == KEY_LSHIFT || key == KEY_RSHIFT) shift_held = 1'b0;
                if (key == KEY_CTRL) ctrl_held = 1'b0;
                if (key == KEY_ALT) alt_held = 1'b0;
            end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
                shift_held = 1'b1;
            end else if (key == KEY_ALT) begin
                alt_held = 1'b1;
            end else if (key == KEY_CTRL) begin
                ctrl_held = 1'b1;
            end else if (key == KEY_CAPS) begin
                caps_lock = !caps_lock;
            end else if (ctrl_held && alt_held && key == KEY_DEL) begin
                r.reboot_request = 1'b1;
            end else if (key >= KEY_F1 && key <= KEY_F5) begin
                // function keys are consumed
            end else begin
                ch = CH_NUL;
                if (code < 8'd64) begin
                    ch = shift_held ? SHIFTED_CHARS[code[5:0]] : PLAIN_CHARS[code[5:0]];
                end
                if (caps_lock) begin
                    if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
                        ch = ch + CH_CASE;
                    end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
                        ch = ch - CH_CASE;
                    end
                end
                if (ctrl_held && ch == CH_LO_C) begin
                    r.interrupt_signal = 1'b1;
                    ch = CH_NEWLINE;
                end
                if (ctrl_held && (ch == CH_LO_D || ch == CH_UP_D)) ch = CH_EOT;
                r.overflow = queue_char(ch);
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic fn, input logic [7:0] code, input logic typed,
                             input kbd_result_t want);
        kbd_result_t predicted;
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= fn;
        i_scan_code <= code;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = decode_item(fn, code);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_scan(input logic [7:0] code);
        send_item(FUNC_SCAN, code, 1'b0, QUIET);
    endtask

    // hold the input channel until every predicted result has arrived
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic [7:0] noise_byte(input bit allow_prefix);
        int n;
        n = $urandom_range(0, allow_prefix ? 255 : 254);
        if (!allow_prefix && n >= SC_PREFIX) n++;
        return 8'(n);
    endfunction

    task automatic arrow_phrase();
        logic [7:0] k;
        while (e0_count < PFX_TWO) send_scan(SC_PREFIX);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0:       k = {1'b0, KEY_DEL};
                1:       k = {1'b0, KEY_ALT};
                default: k = {1'b0, KEY_CTRL};
            endcase
            k[7] = 1'($urandom_range(0, 1));
            send_scan(k);
        end
        case ($urandom_range(0, 4))
            0:       k = {1'b0, KEY_UP};
            1:       k = {1'b0, KEY_DOWN};
            2:       k = {1'b0, KEY_LEFT};
            3:       k = {1'b0, KEY_RIGHT};
            default: begin
                k[6:0] = 7'($urandom_range(0, 8'h7E));
                if (k[6:0] >= 7'h60) k[6:0] = k[6:0] + 7'd1;
            end
        endcase
        k[7] = ($urandom_range(0, 3) != 0);
        send_scan(k);
    endtask

    task automatic random_phrase(input int read_pct, input bit late);
        logic [7:0] k;
        if ($urandom_range(0, 99) < read_pct) begin
            repeat ($urandom_range(1, 3)) send_item(FUNC_READ, noise_byte(1'b1), 1'b0, QUIET);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    k = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 8'h7F))
                                                    : 8'($urandom_range(0, 8'h3F));
                    send_scan(k);
                    if ($urandom_range(0, 1) && (k | 8'h80) != SC_PREFIX) send_scan(k | 8'h80);
                end
                4: begin
                    case ($urandom_range(0, 4))
                        0:       k = {1'b0, KEY_LSHIFT};
                        1:       k = {1'b0, KEY_RSHIFT};
                        2:       k = {1'b0, KEY_CTRL};
                        3:       k = {1'b0, KEY_ALT};
                        default: k = {1'b0, KEY_CAPS};
                    endcase
                    k[7] = 1'($urandom_range(0, 1));
                    send_scan(k);
                end
                5, 6: arrow_phrase();
                7: begin
                    send_scan({1'b0, KEY_CTRL});
                    case ($urandom_range(0, 2))
                        0:       send_scan(8'h2E);
                        1:       send_scan(8'h20);
                        default: send_scan(8'($urandom_range(0, 8'h3F)));
                    endcase
                    if ($urandom_range(0, 1)) send_scan({1'b1, KEY_CTRL});
                end
                8: begin
                    send_scan({1'b0, KEY_CTRL});
                    send_scan({1'b0, KEY_ALT});
                    if ($urandom_range(0, 1)) begin
                        send_scan({1'b0, KEY_DEL});
                    end else begin
                        while (e0_count < PFX_TWO) send_scan(SC_PREFIX);
                        send_scan({1'($urandom_range(0, 1)), KEY_DEL});
                    end
                    if ($urandom_range(0, 1)) send_scan({1'b1, KEY_CTRL});
                    if ($urandom_range(0, 1)) send_scan({1'b1, KEY_ALT});
                end
                default: begin
                    // broken prefix: sometimes a lone E0, then stray bytes
                    if (e0_count == PFX_NONE && $urandom_range(0, 2) == 0) send_scan(SC_PREFIX);
                    repeat ($urandom_range(1, 3)) send_scan(noise_byte(late));
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        kbd_result_t want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result transfer expected none actual %0h", $time,
                         {o_reboot_request, o_interrupt_signal, o_overflow,
                          o_read_valid, o_read_char});
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("reboot_request", 7'(want.reboot_request),
                            7'(o_reboot_request));
                check_field("interrupt_signal", 7'(want.interrupt_signal),
                            7'(o_interrupt_signal));
                check_field("overflow", 7'(want.overflow), 7'(o_overflow));
                check_field("read_valid", 7'(want.read_valid), 7'(o_read_valid));
                check_field("read_char", want.read_char, o_read_char);
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int mark;
        int n;
        int read_pct;
        bit late;
        late = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < $size(DIRECTED); r++) begin
            send_item(DIRECTED[r].func, DIRECTED[r].code, DIRECTED[r].typed, DIRECTED[r].want);
        end
        drain_results();
        mark = items_sent;
        while (items_sent - mark < RANDOM_ITEMS) begin
            n = items_sent - mark;
            if (n >= 650 && n < 900 && !calm) begin
                drain_results();
                calm = 1'b1;
            end
            if (n >= 900) calm = 1'b0;
            if (n >= 1120 && !late) begin
                // saturate the prefix count for the tail of the run
                while (e0_count != PFX_SAT) send_scan(SC_PREFIX);
                late = 1'b1;
            end
            read_pct = (n < 200)  ? 40 :
                       (n < 500)  ? 5  :
                       (n < 650)  ? 70 :
                       (n < 900)  ? 25 :
                       (n < 1050) ? 3  : 60;
            random_phrase(read_pct, late);
        end
        drain_results();
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
